// ===== design/sapm_pkg.sv =====
package sapm_pkg;

  localparam int COEF_W = 16;
  localparam int EXP_W  = 16;
  localparam int SUM_W  = COEF_W + 1;

  typedef enum logic [1:0] {
    CMD_APPEND_A = 2'd0,
    CMD_APPEND_B = 2'd1,
    CMD_MERGE    = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_FETCH,
    S_STEP,
    S_FLUSH
  } state_t;

  typedef struct packed {
    logic [COEF_W-1:0] coef;
    logic [EXP_W-1:0]  exp;
  } term_t;

  // outcome of one merge step
  typedef struct packed {
    logic              take_a;
    logic              take_b;
    logic              emit;
    logic [SUM_W-1:0]  coef;
    logic [EXP_W-1:0]  exp;
  } step_t;

endpackage

// ===== design/sapm_term_mem.sv =====
module sapm_term_mem import sapm_pkg::*; #(
  parameter int DEPTH = 32,
  parameter int AW    = 5
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  term_t         wr_term,
  input  logic [AW-1:0] rd_addr,
  output term_t         rd_term
);

  term_t mem [DEPTH];
  term_t rd_term_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_term;
    end
    rd_term_r <= mem[rd_addr];
  end

  assign rd_term = rd_term_r;

endmodule

// ===== design/sapm_merge_alu.sv =====
module sapm_merge_alu import sapm_pkg::*; (
  input  term_t a_term,
  input  term_t b_term,
  input  logic  a_left,
  input  logic  b_left,
  output step_t step
);

  logic [SUM_W-1:0] a_ext;
  logic [SUM_W-1:0] b_ext;
  logic [SUM_W-1:0] sum;

  assign a_ext = {a_term.coef[COEF_W-1], a_term.coef};
  assign b_ext = {b_term.coef[COEF_W-1], b_term.coef};
  assign sum   = a_ext + b_ext;

  always_comb begin
    step = '0;
    priority if (a_left && b_left) begin
      priority if (a_term.exp > b_term.exp) begin
        step.take_a = 1'b1;
        step.emit   = 1'b1;
        step.coef   = a_ext;
        step.exp    = a_term.exp;
      end else if (a_term.exp < b_term.exp) begin
        step.take_b = 1'b1;
        step.emit   = 1'b1;
        step.coef   = b_ext;
        step.exp    = b_term.exp;
      end else begin
        // equal exponents: add, drop a zero sum
        step.take_a = 1'b1;
        step.take_b = 1'b1;
        step.emit   = (sum != '0);
        step.coef   = sum;
        step.exp    = a_term.exp;
      end
    end else if (a_left) begin
      step.take_a = 1'b1;
      step.emit   = 1'b1;
      step.coef   = a_ext;
      step.exp    = a_term.exp;
    end else if (b_left) begin
      step.take_b = 1'b1;
      step.emit   = 1'b1;
      step.coef   = b_ext;
      step.exp    = b_term.exp;
    end else begin
      // both lists used up: no step
      step.emit   = 1'b0;
    end
  end

endmodule

// ===== design/sparse_polynomial_add_merge.sv =====
// Sparse polynomial adder. Beats with tuser = append-A or append-B store one
// term (coefficient in tdata[15:0], exponent in tdata[31:16]); zero
// coefficients are dropped and a term for a full list sets the sticky
// overflow flag. A merge beat walks both lists in descending exponent order,
// each step a registered memory read, then compare/add in the single shared
// unit; an output stall holds the walk. Each result beat carries the term, with
// tuser[1] the overflow flag as of the merge start, and tlast on the final
// beat; an all-cancelled sum gives one beat with tuser[0] (empty) set. The
// merge clears both lists and the flag. in_tready is low during a merge.
module sparse_polynomial_add_merge import sapm_pkg::*; #(
  parameter int MAX_TERMS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // coefficient[15:0], exponent[31:16]
  input  logic [1:0]  in_tuser,   // command[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // sum_coefficient[16:0], sum_exponent[32:17], zero pad
  output logic [1:0]  out_tuser,  // is_empty[0], overflowed[1]
  output logic        out_tlast
);

  localparam int CNT_W = $clog2(MAX_TERMS + 1);
  localparam int AW    = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_TERMS);

  state_t state_r, state_nxt;
  logic [CNT_W-1:0] count_a_r, count_a_nxt;
  logic [CNT_W-1:0] count_b_r, count_b_nxt;
  logic [CNT_W-1:0] ia_r, ia_nxt;
  logic [CNT_W-1:0] ib_r, ib_nxt;
  logic             ovf_r, ovf_nxt;
  logic             pend_vld_r, pend_vld_nxt;
  logic             out_vld_r, out_vld_nxt;

  logic [SUM_W-1:0] pend_coef_r, pend_coef_nxt;
  logic [EXP_W-1:0] pend_exp_r, pend_exp_nxt;
  logic [SUM_W-1:0] out_coef_r, out_coef_nxt;
  logic [EXP_W-1:0] out_exp_r, out_exp_nxt;
  logic             out_empty_r, out_empty_nxt;
  logic             out_ovf_r, out_ovf_nxt;
  logic             out_last_r, out_last_nxt;

  logic             in_acc;
  logic             out_free;
  logic             wr_a, wr_b;
  term_t            in_term;
  term_t            a_term, b_term;
  logic             a_left, b_left;
  step_t            step;
  cmd_t             cmd;

  assign cmd      = cmd_t'(in_tuser);
  assign in_tready = (state_r == S_IDLE);
  assign in_acc   = in_tvalid && in_tready;
  assign out_free = !out_vld_r || out_tready;
  assign in_term.coef = in_tdata[15:0];
  assign in_term.exp  = in_tdata[31:16];
  assign a_left   = (ia_r < count_a_r);
  assign b_left   = (ib_r < count_b_r);

  sapm_term_mem #(.DEPTH(MAX_TERMS), .AW(AW)) u_mem_a (
    .clk     (clk),
    .wr_en   (wr_a),
    .wr_addr (count_a_r[AW-1:0]),
    .wr_term (in_term),
    .rd_addr (ia_r[AW-1:0]),
    .rd_term (a_term)
  );

  sapm_term_mem #(.DEPTH(MAX_TERMS), .AW(AW)) u_mem_b (
    .clk     (clk),
    .wr_en   (wr_b),
    .wr_addr (count_b_r[AW-1:0]),
    .wr_term (in_term),
    .rd_addr (ib_r[AW-1:0]),
    .rd_term (b_term)
  );

  sapm_merge_alu u_alu (
    .a_term (a_term),
    .b_term (b_term),
    .a_left (a_left),
    .b_left (b_left),
    .step   (step)
  );

  always_comb begin
    state_nxt     = state_r;
    count_a_nxt   = count_a_r;
    count_b_nxt   = count_b_r;
    ia_nxt        = ia_r;
    ib_nxt        = ib_r;
    ovf_nxt       = ovf_r;
    pend_vld_nxt  = pend_vld_r;
    pend_coef_nxt = pend_coef_r;
    pend_exp_nxt  = pend_exp_r;
    out_vld_nxt   = out_vld_r && !out_tready;
    out_coef_nxt  = out_coef_r;
    out_exp_nxt   = out_exp_r;
    out_empty_nxt = out_empty_r;
    out_ovf_nxt   = out_ovf_r;
    out_last_nxt  = out_last_r;
    wr_a          = 1'b0;
    wr_b          = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          unique case (cmd)
            CMD_APPEND_A: begin
              if (in_term.coef != '0) begin
                if (count_a_r < MAX_CNT) begin
                  wr_a        = 1'b1;
                  count_a_nxt = count_a_r + 1'b1;
                end else begin
                  ovf_nxt = 1'b1;
                end
              end
            end
            CMD_APPEND_B: begin
              if (in_term.coef != '0) begin
                if (count_b_r < MAX_CNT) begin
                  wr_b        = 1'b1;
                  count_b_nxt = count_b_r + 1'b1;
                end else begin
                  ovf_nxt = 1'b1;
                end
              end
            end
            CMD_MERGE: begin
              ia_nxt       = '0;
              ib_nxt       = '0;
              pend_vld_nxt = 1'b0;
              if ((count_a_r != '0) || (count_b_r != '0)) begin
                state_nxt = S_FETCH;
              end else begin
                state_nxt = S_FLUSH;
              end
            end
            default: ;
          endcase
        end
      end

      S_FETCH: begin
        state_nxt = S_STEP;
      end

      S_STEP: begin
        // hold while the new term would push a pending one into a busy output
        if (!(step.emit && pend_vld_r && !out_free)) begin
          ia_nxt = ia_r + CNT_W'(step.take_a);
          ib_nxt = ib_r + CNT_W'(step.take_b);
          if (step.emit) begin
            if (pend_vld_r) begin
              out_vld_nxt   = 1'b1;
              out_coef_nxt  = pend_coef_r;
              out_exp_nxt   = pend_exp_r;
              out_empty_nxt = 1'b0;
              out_ovf_nxt   = ovf_r;
              out_last_nxt  = 1'b0;
            end
            pend_vld_nxt  = 1'b1;
            pend_coef_nxt = step.coef;
            pend_exp_nxt  = step.exp;
          end
          if ((ia_nxt < count_a_r) || (ib_nxt < count_b_r)) begin
            state_nxt = S_FETCH;
          end else begin
            state_nxt = S_FLUSH;
          end
        end
      end

      S_FLUSH: begin
        if (out_free) begin
          out_vld_nxt   = 1'b1;
          out_coef_nxt  = pend_vld_r ? pend_coef_r : '0;
          out_exp_nxt   = pend_vld_r ? pend_exp_r : '0;
          out_empty_nxt = !pend_vld_r;
          out_ovf_nxt   = ovf_r;
          out_last_nxt  = 1'b1;
          pend_vld_nxt  = 1'b0;
          count_a_nxt   = '0;
          count_b_nxt   = '0;
          ovf_nxt       = 1'b0;
          state_nxt     = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      count_a_r  <= '0;
      count_b_r  <= '0;
      ia_r       <= '0;
      ib_r       <= '0;
      ovf_r      <= 1'b0;
      pend_vld_r <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      count_a_r  <= count_a_nxt;
      count_b_r  <= count_b_nxt;
      ia_r       <= ia_nxt;
      ib_r       <= ib_nxt;
      ovf_r      <= ovf_nxt;
      pend_vld_r <= pend_vld_nxt;
      out_vld_r  <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_coef_r <= pend_coef_nxt;
    pend_exp_r  <= pend_exp_nxt;
    out_coef_r  <= out_coef_nxt;
    out_exp_r   <= out_exp_nxt;
    out_empty_r <= out_empty_nxt;
    out_ovf_r   <= out_ovf_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {7'd0, out_exp_r, out_coef_r};
  assign out_tuser  = {out_ovf_r, out_empty_r};
  assign out_tlast  = out_last_r;

endmodule
